// ===== rtl/mtcqf_pkg.sv =====
// shared types, constants and helpers for the midi time code quarter frame receiver
package mtcqf_pkg;

    localparam logic [7:0] QF_STATUS   = 8'hF1;
    localparam logic [3:0] NO_PIECE    = 4'd15;
    localparam logic [7:0] WIN_MIN_RST = 8'd30;
    localparam logic [7:0] WIN_MAX_RST = 8'd45;

    // register index decoded from the word address
    localparam logic REG_WIN_MIN = 1'b0;
    localparam logic REG_WIN_MAX = 1'b1;

    localparam logic [1:0] RATE_24   = 2'd0;
    localparam logic [1:0] RATE_25   = 2'd1;
    localparam logic [1:0] RATE_30DF = 2'd2;
    localparam logic [1:0] RATE_30   = 2'd3;

    // hours sit in the lowest bits, rate in the highest
    typedef struct packed {
        logic [1:0] rate;
        logic [4:0] frames;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
    } tc_t;

    // highest frame label for a rate code
    function automatic logic [4:0] fps_last(input logic [1:0] rate);
        logic [4:0] r;
        unique case (rate)
            RATE_24: r = 5'd23;
            RATE_25: r = 5'd24;
            default: r = 5'd29;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mtcqf_advance.sv =====
// adds two or three frames to a timecode with smpte counting and drop-frame
module mtcqf_advance
    import mtcqf_pkg::*;
(
    input  tc_t  tc_i,
    input  logic add_three,
    output tc_t  tc_o
);

    function automatic logic is_tens(input logic [5:0] m);
        return (m == 6'd0) || (m == 6'd10) || (m == 6'd20) || (m == 6'd30) ||
               (m == 6'd40) || (m == 6'd50);
    endfunction

    function automatic tc_t step1(input tc_t t);
        tc_t        r;
        logic [4:0] fr;
        r  = t;
        fr = t.frames + 5'd1;
        if (fr > fps_last(t.rate)) begin
            r.frames = 5'd0;
            if (t.seconds >= 6'd59) begin
                r.seconds = 6'd0;
                if (t.minutes >= 6'd59) begin
                    r.minutes = 6'd0;
                    r.hours   = (t.hours >= 5'd23) ? 5'd0 : t.hours + 5'd1;
                end else begin
                    r.minutes = t.minutes + 6'd1;
                end
            end else begin
                r.seconds = t.seconds + 6'd1;
            end
        end else begin
            r.frames = fr;
        end
        // drop-frame skips labels 0 and 1 except on every tenth minute
        if (r.rate == RATE_30DF && r.frames == 5'd0 && r.seconds == 6'd0 &&
            !is_tens(r.minutes)) begin
            r.frames = 5'd2;
        end
        return r;
    endfunction

    tc_t s1, s2, s3;

    always_comb begin
        s1   = step1(tc_i);
        s2   = step1(s1);
        s3   = step1(s2);
        tc_o = add_three ? s3 : s2;
    end

endmodule

// ===== rtl/midi_timecode_quarter_frame_receiver.sv =====
// top level of the midi time code quarter frame receiver
//
//  channel  | ports                      | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | s_tvalid s_tready s_tdata  | time_ms, status_byte, data_byte
//  out      | m_tvalid m_tready m_tdata  | tc_hours, tc_minutes, tc_seconds,
//           |                            | tc_frames, tc_rate
//  config   | psel penable pwrite paddr  | window_min_ms @0x0, window_max_ms @0x4
//
//  one message per cycle: an input register, then one pass of logic into the result
//  register; the frame adder (up to three chained frame steps) sets the path.
//  the result register loads from the input register when the message advances.
//  a stalled result holds the message in the input register; s_tready stays low
//  while both registers are full and m_tready is low.
//  reset is synchronous on aresetn low and restores windows 30 and 45 ms.
module midi_timecode_quarter_frame_receiver
    import mtcqf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [30:0] time_ms, [38:31] status_byte, [46:39] data_byte, [47] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] tc_hours, [10:5] tc_minutes, [16:11] tc_seconds, [21:17] tc_frames,
    // [23:22] tc_rate
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  win_min_reg, win_min_next;
    logic [7:0]  win_max_reg, win_max_next;
    logic        in_valid_reg, in_valid_next;
    logic [30:0] in_time_reg;
    logic [7:0]  in_status_reg;
    logic [7:0]  in_data_reg;
    logic [3:0]  nib_reg [8];
    logic [3:0]  nib_next [8];
    logic [3:0]  last_piece_reg, last_piece_next;
    logic [30:0] last0_time_reg, last0_time_next;
    tc_t         held_reg, held_next;
    logic        m_valid_reg, m_valid_next;
    tc_t         out_tc_reg;

    logic        advance;
    logic        is_qf;
    logic [2:0]  piece;
    logic [3:0]  nib;
    logic [30:0] gap;
    logic        emit0, emit4, emit;
    logic        in_order;
    tc_t         assembled;
    tc_t         adv_tc;
    logic [7:0]  raw_fr, raw_sec, raw_min;
    logic [4:0]  raw_hr;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == REG_WIN_MAX) ? win_max_reg : win_min_reg};

    always_comb begin
        win_min_next = win_min_reg;
        win_max_next = win_max_reg;
        if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_WIN_MIN: win_min_next = pwdata[7:0];
                REG_WIN_MAX: win_max_next = pwdata[7:0];
                default:     win_min_next = win_min_reg;
            endcase
        end
    end

    // handshake
    assign advance       = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    // message decode
    assign is_qf = (in_status_reg == QF_STATUS);
    assign piece = in_data_reg[6:4];
    assign nib   = in_data_reg[3:0];
    assign gap   = (in_time_reg >= last0_time_reg) ? in_time_reg - last0_time_reg : 31'd0;

    assign emit0 = is_qf && piece == 3'd0 && last_piece_reg == 4'd7 &&
                   gap > {22'd0, win_min_reg, 1'b0} && gap < {22'd0, win_max_reg, 1'b0};
    assign emit4 = is_qf && piece == 3'd4 && last_piece_reg == 4'd3 &&
                   gap > {23'd0, win_min_reg} && gap < {23'd0, win_max_reg};
    assign emit  = emit0 || emit4;

    assign in_order = (piece == 3'd0) ||
                      ({2'b00, piece} == {1'b0, last_piece_reg} + 5'd1);

    // timecode from stored nibbles, nibble 7 as held before this message
    always_comb begin
        raw_fr  = {nib_reg[1], nib_reg[0]};
        raw_sec = {nib_reg[3], nib_reg[2]};
        raw_min = {nib_reg[5], nib_reg[4]};
        raw_hr  = {nib_reg[7][0], nib_reg[6]};
        assembled.rate    = nib_reg[7][2:1];
        assembled.frames  = (raw_fr > {3'd0, fps_last(nib_reg[7][2:1])}) ?
                            fps_last(nib_reg[7][2:1]) : raw_fr[4:0];
        assembled.seconds = (raw_sec > 8'd59) ? 6'd59 : raw_sec[5:0];
        assembled.minutes = (raw_min > 8'd59) ? 6'd59 : raw_min[5:0];
        assembled.hours   = (raw_hr > 5'd23) ? 5'd23 : raw_hr;
    end

    mtcqf_advance u_advance (
        .tc_i      (held_reg),
        .add_three (emit4),
        .tc_o      (adv_tc)
    );

    // state update
    always_comb begin
        nib_next        = nib_reg;
        last_piece_next = last_piece_reg;
        last0_time_next = last0_time_reg;
        held_next       = held_reg;
        if (advance && is_qf) begin
            if (piece == 3'd7 && last_piece_reg == 4'd6) begin
                held_next = assembled;
            end
            if (piece == 3'd0) begin
                last0_time_next = in_time_reg;
            end
            if (in_order) begin
                last_piece_next = {1'b0, piece};
                nib_next[piece] = nib;
            end
        end
    end

    assign m_valid_next = advance ? emit : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_min_reg    <= WIN_MIN_RST;
            win_max_reg    <= WIN_MAX_RST;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_piece_reg <= NO_PIECE;
            last0_time_reg <= 31'd0;
            held_reg       <= '0;
            for (int i = 0; i < 8; i++) begin
                nib_reg[i] <= 4'd0;
            end
        end else begin
            win_min_reg    <= win_min_next;
            win_max_reg    <= win_max_next;
            in_valid_reg   <= in_valid_next;
            m_valid_reg    <= m_valid_next;
            last_piece_reg <= last_piece_next;
            last0_time_reg <= last0_time_next;
            held_reg       <= held_next;
            nib_reg        <= nib_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg   <= s_tdata[30:0];
            in_status_reg <= s_tdata[38:31];
            in_data_reg   <= s_tdata[46:39];
        end
        if (advance && emit) begin
            out_tc_reg <= adv_tc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_tc_reg;

    // last piece is either none or a real piece number
    a_last_piece: assert property (@(posedge aclk) disable iff (!aresetn)
        last_piece_reg[3] == 1'b0 || last_piece_reg == NO_PIECE)
        else $error("last piece holds an impossible value");

    // a message stalls only behind a result that is held back
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // emitted frames stay below the frame rate
    a_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_tc_reg.frames <= fps_last(out_tc_reg.rate))
        else $error("emitted frame label out of range");

    // emitted clock fields stay in range
    a_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_tc_reg.hours <= 5'd23 && out_tc_reg.minutes <= 6'd59 &&
                         out_tc_reg.seconds <= 6'd59))
        else $error("emitted time field out of range");

endmodule
